@@ hdl/rmmh_pkg.sv @@
package rmmh_pkg;

  // Distances are unsigned hundredths of a centimeter
  localparam int unsigned DistW          = 16;
  localparam int unsigned SensorW        = 3;
  localparam int unsigned RingDepth      = 3;
  localparam int unsigned FootHundredths = 3048;
  localparam int unsigned MaxFeet        = 10;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned ApbAddrW       = 5;
  localparam int unsigned ApbDataW       = 32;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_MIN_VALID    = 3'd0,
    REG_MAX_VALID    = 3'd1,
    REG_MOTOR_MAX    = 3'd2,
    REG_ON_STEP      = 3'd3,
    REG_OFF_STEP     = 3'd4,
    REG_AUDIO_SENSOR = 3'd5
  } reg_idx_e;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_TIMEOUT = 3'd1,
    STATUS_INVALID = 3'd2,
    STATUS_WARMUP  = 3'd3,
    STATUS_BAD_IDX = 3'd4
  } status_e;

  // Input action codes
  localparam logic ACTION_READING = 1'b0;
  localparam logic ACTION_TIMEOUT = 1'b1;

  // Class of a queued beat, decided by the front end
  typedef enum logic [1:0] {
    KIND_BAD_IDX = 2'd0,
    KIND_TIMEOUT = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_READING = 2'd3
  } kind_e;

  typedef struct packed {
    logic               action;
    logic [SensorW-1:0] sensor;
    logic [DistW-1:0]   distance;
  } in_t;

  typedef struct packed {
    logic [SensorW-1:0] sensor_out;
    logic [2:0]         status;
    logic [DistW-1:0]   filtered;
    logic               motor_update;
    logic               motor_level;
    logic               audio_request;
    logic [3:0]         audio_feet;
  } out_t;

  typedef struct packed {
    logic [DistW-1:0]   min_valid;
    logic [DistW-1:0]   max_valid;
    logic [DistW-1:0]   motor_max;
    logic [DistW-1:0]   on_step;
    logic [DistW-1:0]   off_step;
    logic [SensorW-1:0] audio_sensor;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [SensorW-1:0] sensor;
    logic [DistW-1:0]   distance;
  } entry_t;

  // Median of three
  function automatic logic [DistW-1:0] mid3(logic [DistW-1:0] a, logic [DistW-1:0] b,
                                            logic [DistW-1:0] c);
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;
    logic [DistW-1:0] m;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    m  = (hi > c) ? c : hi;
    m  = (lo > m) ? lo : m;
    return m;
  endfunction

  // Whole feet, floor(d / 3048), counted by threshold compares; valid for 0..MaxFeet
  function automatic logic [3:0] feet_of(logic [DistW-1:0] d);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k <= MaxFeet; k++) begin
      if (32'(d) >= k * FootHundredths) n = n + 4'd1;
    end
    return n;
  endfunction

  // Filtered distance lies within 1 to 10 whole feet
  function automatic logic feet_in_range(logic [DistW-1:0] d);
    return (32'(d) >= FootHundredths) && (32'(d) < (MaxFeet + 1) * FootHundredths);
  endfunction

endpackage

@@ hdl/rmmh_regs.sv @@
module rmmh_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmmh_pkg::ApbAddrW-1:0] paddr,
  input  logic [rmmh_pkg::ApbDataW-1:0] pwdata,
  output logic [rmmh_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output rmmh_pkg::cfg_t                cfg_o
);

  rmmh_pkg::cfg_t     cfg_q, cfg_d;
  rmmh_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = rmmh_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        rmmh_pkg::REG_MIN_VALID:    cfg_d.min_valid    = pwdata[15:0];
        rmmh_pkg::REG_MAX_VALID:    cfg_d.max_valid    = pwdata[15:0];
        rmmh_pkg::REG_MOTOR_MAX:    cfg_d.motor_max    = pwdata[15:0];
        rmmh_pkg::REG_ON_STEP:      cfg_d.on_step      = pwdata[15:0];
        rmmh_pkg::REG_OFF_STEP:     cfg_d.off_step     = pwdata[15:0];
        rmmh_pkg::REG_AUDIO_SENSOR: cfg_d.audio_sensor = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_valid    <= 16'd200;
      cfg_q.max_valid    <= 16'd40000;
      cfg_q.motor_max    <= 16'd30880;
      cfg_q.on_step      <= 16'd1000;
      cfg_q.off_step     <= 16'd300;
      cfg_q.audio_sensor <= 3'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      rmmh_pkg::REG_MIN_VALID:    prdata = 32'(cfg_q.min_valid);
      rmmh_pkg::REG_MAX_VALID:    prdata = 32'(cfg_q.max_valid);
      rmmh_pkg::REG_MOTOR_MAX:    prdata = 32'(cfg_q.motor_max);
      rmmh_pkg::REG_ON_STEP:      prdata = 32'(cfg_q.on_step);
      rmmh_pkg::REG_OFF_STEP:     prdata = 32'(cfg_q.off_step);
      rmmh_pkg::REG_AUDIO_SENSOR: prdata = 32'(cfg_q.audio_sensor);
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ hdl/rmmh_front.sv @@
module rmmh_front #(
  parameter int unsigned SENSORS = 2
) (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rmmh_pkg::in_t   in_i,
  input  rmmh_pkg::cfg_t  cfg_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output rmmh_pkg::entry_t q_entry_o
);

  logic bad_idx;
  logic out_window;

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

  assign bad_idx    = 32'(in_i.sensor) >= SENSORS;
  // Crossed window rejects everything on its own
  assign out_window = (in_i.distance < cfg_i.min_valid) || (in_i.distance > cfg_i.max_valid);

  // Classify the beat
  always_comb begin
    q_entry_o.sensor   = in_i.sensor;
    q_entry_o.distance = in_i.distance;
    if (bad_idx) begin
      q_entry_o.kind = rmmh_pkg::KIND_BAD_IDX;
    end else if (in_i.action == rmmh_pkg::ACTION_TIMEOUT) begin
      q_entry_o.kind = rmmh_pkg::KIND_TIMEOUT;
    end else if (out_window) begin
      q_entry_o.kind = rmmh_pkg::KIND_INVALID;
    end else begin
      q_entry_o.kind = rmmh_pkg::KIND_READING;
    end
  end

endmodule

@@ hdl/rmmh_queue.sv @@
module rmmh_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rmmh_pkg::entry_t entry_i,
  output logic             ready_o,
  output logic             valid_o,
  output rmmh_pkg::entry_t entry_o,
  input  logic             pop_i
);

  localparam int unsigned PtrW = (rmmh_pkg::QueueDepth > 1) ? $clog2(rmmh_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(rmmh_pkg::QueueDepth + 1);

  rmmh_pkg::entry_t slots_q [rmmh_pkg::QueueDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign ready_o = cnt_q != CntW'(rmmh_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = slots_q[rptr_q];

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(rmmh_pkg::QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(rmmh_pkg::QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wptr_q] <= entry_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(rmmh_pkg::QueueDepth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count missed a push");

endmodule

@@ hdl/rmmh_back.sv @@
module rmmh_back #(
  parameter int unsigned SENSORS = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rmmh_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  rmmh_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rmmh_pkg::out_t   out_o
);

  localparam int unsigned SidxW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned DW    = rmmh_pkg::DistW;

  // Per-sensor state
  logic [DW-1:0] ring_q [SENSORS][rmmh_pkg::RingDepth];
  logic [1:0]    slot_q  [SENSORS];
  logic [1:0]    cnt_q   [SENSORS];
  logic [DW-1:0] filt_q  [SENSORS];
  logic          ready_q [SENSORS];
  logic          motor_q [SENSORS];

  rmmh_pkg::out_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic [SidxW-1:0]    sidx;
  logic [1:0]          slot, slot_next, cnt_next;
  logic [DW-1:0]       smp0, smp1, smp2, median;
  logic signed [DW+1:0] approach;
  logic                motor_next, wr_state, is_timeout, is_reading, full;

  assign sidx       = q_entry_i.sensor[SidxW-1:0];
  assign q_pop_o    = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_timeout = q_entry_i.kind == rmmh_pkg::KIND_TIMEOUT;
  assign is_reading = q_entry_i.kind == rmmh_pkg::KIND_READING;
  assign wr_state   = q_pop_o && (is_timeout || is_reading);

  // Ring slot and fill count after this reading
  always_comb begin
    slot      = (slot_q[sidx] == 2'd3) ? 2'd0 : slot_q[sidx];
    slot_next = (slot == 2'(rmmh_pkg::RingDepth - 1)) ? 2'd0 : slot + 2'd1;
    cnt_next  = (cnt_q[sidx] < 2'(rmmh_pkg::RingDepth)) ? cnt_q[sidx] + 2'd1 : cnt_q[sidx];
    full      = cnt_next == 2'(rmmh_pkg::RingDepth);
  end

  // Ring contents with the new reading in place, then the median
  always_comb begin
    smp0   = (slot == 2'd0) ? q_entry_i.distance : ring_q[sidx][0];
    smp1   = (slot == 2'd1) ? q_entry_i.distance : ring_q[sidx][1];
    smp2   = (slot == 2'd2) ? q_entry_i.distance : ring_q[sidx][2];
    median = rmmh_pkg::mid3(smp0, smp1, smp2);
  end

  // Motor hysteresis on approach = previous - new
  always_comb begin
    approach   = $signed({2'b00, filt_q[sidx]}) - $signed({2'b00, median});
    motor_next = motor_q[sidx];
    if (median > cfg_i.motor_max) begin
      motor_next = 1'b0;
    end else if (!motor_q[sidx] && approach >= $signed({2'b00, cfg_i.on_step})) begin
      motor_next = 1'b1;
    end else if (motor_q[sidx] && approach <= $signed({2'b00, cfg_i.off_step})) begin
      motor_next = 1'b0;
    end
  end

  // Result beat
  always_comb begin
    out_d            = '0;
    out_d.sensor_out = q_entry_i.sensor;
    case (q_entry_i.kind)
      rmmh_pkg::KIND_BAD_IDX: begin
        out_d.status = rmmh_pkg::STATUS_BAD_IDX;
      end
      rmmh_pkg::KIND_TIMEOUT: begin
        out_d.status       = rmmh_pkg::STATUS_TIMEOUT;
        out_d.filtered     = filt_q[sidx];
        out_d.motor_update = 1'b1;
        out_d.motor_level  = 1'b0;
      end
      rmmh_pkg::KIND_INVALID: begin
        out_d.status      = rmmh_pkg::STATUS_INVALID;
        out_d.filtered    = filt_q[sidx];
        out_d.motor_level = motor_q[sidx];
      end
      default: begin
        if (!full) begin
          out_d.status      = rmmh_pkg::STATUS_WARMUP;
          out_d.filtered    = filt_q[sidx];
          out_d.motor_level = motor_q[sidx];
        end else begin
          out_d.status       = rmmh_pkg::STATUS_OK;
          out_d.filtered     = median;
          out_d.motor_update = ready_q[sidx];
          out_d.motor_level  = ready_q[sidx] ? motor_next : motor_q[sidx];
          if (q_entry_i.sensor == cfg_i.audio_sensor && rmmh_pkg::feet_in_range(median)) begin
            out_d.audio_request = 1'b1;
            out_d.audio_feet    = rmmh_pkg::feet_of(median);
          end
        end
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Control state per sensor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSORS; i++) begin
        slot_q[i]  <= '0;
        cnt_q[i]   <= '0;
        filt_q[i]  <= '0;
        ready_q[i] <= 1'b0;
        motor_q[i] <= 1'b0;
      end
    end else if (wr_state) begin
      if (is_timeout) begin
        slot_q[sidx]  <= '0;
        cnt_q[sidx]   <= '0;
        ready_q[sidx] <= 1'b0;
        motor_q[sidx] <= 1'b0;
      end else begin
        slot_q[sidx]  <= slot_next;
        cnt_q[sidx]   <= cnt_next;
        ready_q[sidx] <= full;
        if (full) begin
          filt_q[sidx] <= median;
          if (ready_q[sidx]) motor_q[sidx] <= motor_next;
        end
      end
    end
  end

  // Ring samples, no reset
  always_ff @(posedge clk_i) begin
    if (q_pop_o && is_reading) ring_q[sidx][slot] <= q_entry_i.distance;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.motor_update |->
      out_o.status == rmmh_pkg::STATUS_OK || out_o.status == rmmh_pkg::STATUS_TIMEOUT)
    else $error("motor write on a beat that cannot drive it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.audio_request |->
      out_o.status == rmmh_pkg::STATUS_OK && out_o.audio_feet >= 4'd1 &&
      out_o.audio_feet <= 4'(rmmh_pkg::MaxFeet))
    else $error("audio request out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == rmmh_pkg::STATUS_BAD_IDX |->
      out_o.filtered == '0 && !out_o.motor_level && !out_o.motor_update)
    else $error("bad index beat carries data");

endmodule

@@ hdl/ranging_median_motor_hysteresis_core.sv @@
// Ranging filter with motor hysteresis and audio distance requests.
//
// Input channel (in_valid_i / in_ready_o / in_i): one ultrasonic event per
// beat, either a distance reading or an echo timeout for one sensor.
// Output channel (out_valid_o / out_ready_i / out_o): exactly one result beat
// per event, in event order. Config: APB registers at byte addresses 0x00..0x14,
// which are to be written only while idle; the block itself does not enforce it.
//
// Path: an accepted event is written into the classification queue, then
// moves into the output register, where its result is visible, once the
// output register is free.
// Throughput: one event per cycle while out_ready_i stays high; the per-sensor
// state update, the median of three and the feet conversion are combinational.
//
// Reset clears filters, motors, queue and output. When the receiver stalls,
// the output register holds its beat, the two-entry queue absorbs further
// events, and in_ready_o drops once the queue is full.
module ranging_median_motor_hysteresis_core #(
  parameter int unsigned SENSORS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rmmh_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rmmh_pkg::out_t                out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmmh_pkg::ApbAddrW-1:0] paddr,
  input  logic [rmmh_pkg::ApbDataW-1:0] pwdata,
  output logic [rmmh_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  rmmh_pkg::cfg_t   cfg;
  logic             q_ready, q_push, q_valid, q_pop;
  rmmh_pkg::entry_t q_in, q_out;

  rmmh_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rmmh_front #(.SENSORS(SENSORS)) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  rmmh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .entry_o (q_out),
    .pop_i   (q_pop)
  );

  rmmh_back #(.SENSORS(SENSORS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmmh_pkg::*;

  localparam int unsigned SENSORS   = 2;
  localparam int unsigned WatchLim  = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // event channel
  logic ev_valid = 1'b0;
  logic ev_ready;
  in_t  ev_data = '0;

  // report channel
  logic rep_valid;
  logic rep_ready = 1'b0;
  out_t rep_data;

  // config port
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ranging_median_motor_hysteresis_core #(
    .SENSORS(SENSORS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (ev_valid),
    .in_ready_o (ev_ready),
    .in_i       (ev_data),
    .out_valid_o(rep_valid),
    .out_ready_i(rep_ready),
    .out_o      (rep_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the filter state and registers
  cfg_t            cfg = '{min_valid: 16'd200, max_valid: 16'd40000, motor_max: 16'd30880,
                           on_step: 16'd1000, off_step: 16'd300, audio_sensor: 3'd0};
  logic [DistW-1:0] ring_shadow [SENSORS][RingDepth];
  logic [1:0]       slot_shadow [SENSORS];
  logic [1:0]       count_shadow [SENSORS];
  logic [DistW-1:0] filt_shadow [SENSORS];
  logic             ready_shadow [SENSORS];
  logic             motor_shadow [SENSORS];

  in_t  pending_events [$];
  out_t expected_reports [$];
  int   walk_target [SENSORS];
  int   failures = 0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   quiet_cycles = 0;
  bit   steady = 1'b0;

  initial begin
    for (int s = 0; s < SENSORS; s++) begin
      slot_shadow[s]  = '0;
      count_shadow[s] = '0;
      filt_shadow[s]  = '0;
      ready_shadow[s] = 1'b0;
      motor_shadow[s] = 1'b0;
      walk_target[s]  = 20000;
      for (int k = 0; k < RingDepth; k++) ring_shadow[s][k] = '0;
    end
  end

  function automatic logic [DistW-1:0] median3(logic [DistW-1:0] a, logic [DistW-1:0] b,
                                               logic [DistW-1:0] c);
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return lo;
    if (c > hi) return hi;
    return c;
  endfunction

  // Apply one event to the shadow state and return the report it should produce
  function automatic out_t advance_filter(in_t ev);
    out_t             rep;
    int               s;
    logic             was_ready;
    logic [DistW-1:0] prev;
    int               approach;
    int unsigned      feet;
    rep = '0;
    rep.sensor_out = ev.sensor;
    if (ev.sensor >= SENSORS) begin
      rep.status = STATUS_BAD_IDX;
      return rep;
    end
    s = int'(ev.sensor);
    if (ev.action == ACTION_TIMEOUT) begin
      motor_shadow[s] = 1'b0;
      ready_shadow[s] = 1'b0;
      count_shadow[s] = '0;
      slot_shadow[s]  = '0;
      rep.status = STATUS_TIMEOUT;
      rep.motor_update = 1'b1;
    end else if (ev.distance < cfg.min_valid || ev.distance > cfg.max_valid) begin
      rep.status = STATUS_INVALID;
    end else begin
      was_ready = ready_shadow[s];
      prev = filt_shadow[s];
      ring_shadow[s][slot_shadow[s]] = ev.distance;
      slot_shadow[s] = (slot_shadow[s] == 2'd2) ? 2'd0 : slot_shadow[s] + 2'd1;
      if (count_shadow[s] < RingDepth) count_shadow[s] = count_shadow[s] + 2'd1;
      if (count_shadow[s] < RingDepth) begin
        ready_shadow[s] = 1'b0;
        rep.status = STATUS_WARMUP;
      end else begin
        ready_shadow[s] = 1'b1;
        filt_shadow[s] = median3(ring_shadow[s][0], ring_shadow[s][1], ring_shadow[s][2]);
        rep.status = STATUS_OK;
        // motor only moves once the previous median is meaningful
        if (was_ready) begin
          approach = int'(prev) - int'(filt_shadow[s]);
          if (filt_shadow[s] > cfg.motor_max) begin
            motor_shadow[s] = 1'b0;
          end else if (!motor_shadow[s] && approach >= int'(cfg.on_step)) begin
            motor_shadow[s] = 1'b1;
          end else if (motor_shadow[s] && approach <= int'(cfg.off_step)) begin
            motor_shadow[s] = 1'b0;
          end
          rep.motor_update = 1'b1;
        end
        if (s == int'(cfg.audio_sensor)) begin
          feet = filt_shadow[s] / FootHundredths;
          if (feet >= 1 && feet <= MaxFeet) begin
            rep.audio_request = 1'b1;
            rep.audio_feet = feet[3:0];
          end
        end
      end
    end
    rep.filtered = filt_shadow[s];
    rep.motor_level = motor_shadow[s];
    return rep;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(19, 0);
  endfunction

  // Driver: present queued events, predict on each accepted beat
  always @(posedge clk) begin : drive_events
    logic v;
    in_t  d;
    v = ev_valid;
    d = ev_data;
    if (ev_valid && ev_ready) begin
      expected_reports.push_back(advance_filter(ev_data));
      v = 1'b0;
      send_wait = draw_wait();
    end
    if (!v && rst_n) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending_events.size() > 0) begin
        d = pending_events.pop_front();
        v = 1'b1;
      end
    end
    ev_valid <= v;
    ev_data <= d;
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Monitor: compare each report beat with the oldest prediction
  always @(posedge clk) begin : watch_reports
    logic r;
    out_t want;
    r = rep_ready;
    if (rst_n && rep_valid && rep_ready) begin
      if (expected_reports.size() == 0) begin
        $error("report beat with no event pending: %p", rep_data);
        failures++;
      end else begin
        want = expected_reports.pop_front();
        check_field("sensor_out", want.sensor_out, rep_data.sensor_out);
        check_field("status", want.status, rep_data.status);
        check_field("filtered", want.filtered, rep_data.filtered);
        check_field("motor_update", want.motor_update, rep_data.motor_update);
        check_field("motor_level", want.motor_level, rep_data.motor_level);
        check_field("audio_request", want.audio_request, rep_data.audio_request);
        check_field("audio_feet", want.audio_feet, rep_data.audio_feet);
      end
      recv_wait = draw_wait();
      r = (recv_wait == 0);
    end else if (!rep_ready) begin
      if (recv_wait > 0) recv_wait--;
      if (recv_wait == 0) r = 1'b1;
    end
    rep_ready <= r;
  end

  // Watchdog on cycles with no beat on any port
  always @(posedge clk) begin : watchdog
    if ((ev_valid && ev_ready) || (rep_valid && rep_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLim) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register, then read it back
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (idx == REG_AUDIO_SENSOR) ? 32'h7 : 32'hFFFF;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_VALID:    cfg.min_valid = val;
      REG_MAX_VALID:    cfg.max_valid = val;
      REG_MOTOR_MAX:    cfg.motor_max = val;
      REG_ON_STEP:      cfg.on_step = val;
      REG_OFF_STEP:     cfg.off_step = val;
      REG_AUDIO_SENSOR: cfg.audio_sensor = val[2:0];
      default: ;
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== ({16'd0, val} & mask)) begin
      $error("register %s readback: expected %0h, got %0h", idx.name(), val & mask, rd & mask);
      failures++;
    end
  endtask

  task automatic set_config(input logic [15:0] min_d, input logic [15:0] max_d,
                            input logic [15:0] mmax, input logic [15:0] on_s,
                            input logic [15:0] off_s, input logic [15:0] aud);
    write_reg(REG_MIN_VALID, min_d);
    write_reg(REG_MAX_VALID, max_d);
    write_reg(REG_MOTOR_MAX, mmax);
    write_reg(REG_ON_STEP, on_s);
    write_reg(REG_OFF_STEP, off_s);
    write_reg(REG_AUDIO_SENSOR, aud);
  endtask

  task automatic random_config();
    set_config(16'($urandom_range(1000, 0)), 16'($urandom_range(65535, 30000)),
               16'($urandom_range(40000, 10000)), 16'($urandom_range(3000, 100)),
               16'($urandom_range(800, 0)), 16'($urandom_range(2, 0)));
  endtask

  task automatic add_event(input logic act, input logic [2:0] sen,
                           input logic [15:0] distance_in);
    in_t ev;
    ev.action = act;
    ev.sensor = sen;
    ev.distance = distance_in;
    pending_events.push_back(ev);
  endtask

  // Next reading for a sensor: a walk inside the window, mostly approaching
  function automatic logic [15:0] walk_distance(int s);
    int lo;
    int hi;
    int r;
    lo = int'(cfg.min_valid);
    hi = int'(cfg.max_valid);
    if (lo > hi) return 16'($urandom());
    r = $urandom_range(99, 0);
    if (r < 10) walk_target[s] = $urandom_range(hi, lo);
    else if (r < 65) walk_target[s] -= $urandom_range(3000, 0);
    else if (r < 85) walk_target[s] -= $urandom_range(400, 0);
    else walk_target[s] += $urandom_range(2000, 0);
    if (walk_target[s] < lo) walk_target[s] = lo;
    if (walk_target[s] > hi) walk_target[s] = hi;
    return 16'(walk_target[s]);
  endfunction

  task automatic add_random(input int n);
    int r;
    int s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      s = $urandom_range(SENSORS - 1, 0);
      if (r < 5) add_event(1'($urandom_range(1, 0)), 3'($urandom_range(7, SENSORS)),
                           16'($urandom()));
      else if (r < 11) add_event(ACTION_TIMEOUT, 3'(s), 16'($urandom()));
      else if (r < 18) add_event(ACTION_READING, 3'(s), 16'($urandom()));
      else add_event(ACTION_READING, 3'(s), walk_distance(s));
    end
  endtask

  // Hold off until every predicted report has been seen
  task automatic drain();
    while (pending_events.size() != 0 || ev_valid || expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bad index, timeout, window edges, warm-up, hysteresis, feet edges
    add_event(ACTION_TIMEOUT, 3'd7, 16'hFFFF);
    add_event(ACTION_READING, 3'd2, 16'd0);
    add_event(ACTION_TIMEOUT, 3'd0, 16'd0);
    add_event(ACTION_READING, 3'd0, 16'd0);
    add_event(ACTION_READING, 3'd0, 16'd199);
    add_event(ACTION_READING, 3'd0, 16'd40001);
    add_event(ACTION_READING, 3'd0, 16'hFFFF);
    add_event(ACTION_READING, 3'd0, 16'd200);
    add_event(ACTION_READING, 3'd0, 16'd40000);
    add_event(ACTION_READING, 3'd0, 16'd30000);
    add_event(ACTION_READING, 3'd0, 16'd20000);
    add_event(ACTION_READING, 3'd0, 16'd10000);
    add_event(ACTION_READING, 3'd0, 16'd9900);
    add_event(ACTION_READING, 3'd0, 16'd9900);
    for (int i = 0; i < 3; i++) add_event(ACTION_READING, 3'd1, 16'd5000);
    for (int i = 0; i < 3; i++) add_event(ACTION_READING, 3'd0, 16'd33528);
    for (int i = 0; i < 2; i++) add_event(ACTION_READING, 3'd0, 16'd33527);
    add_event(ACTION_TIMEOUT, 3'd0, 16'd0);
    for (int i = 0; i < 3; i++) add_event(ACTION_READING, 3'd0, 16'd3048);
    drain();

    random_config();
    add_random(110);
    drain();

    // wide window, zero hysteresis, no idling
    steady = 1'b1;
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd1);
    add_random(100);
    drain();

    // crossed window, audio sensor out of range
    steady = 1'b0;
    set_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd7);
    add_random(40);
    drain();

    // motor always forced off, window on whole feet
    set_config(16'd3048, 16'd33528, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1);
    add_random(80);
    drain();

    for (int p = 0; p < 4; p++) begin
      steady = p[0];
      random_config();
      add_random(100);
      drain();
    end

    repeat (10) @(posedge clk);
    if (failures == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rmmh_pkg.sv
hdl/rmmh_regs.sv
hdl/rmmh_front.sv
hdl/rmmh_queue.sv
hdl/rmmh_back.sv
hdl/ranging_median_motor_hysteresis_core.sv
test/tb.sv
